### sv/cordic_ii_vectoring_angle_magnitude_macros.svh
// ----------------------------------------------------------------------------
// cvam assertion macros
// shared concurrent assertion forms for the cordic ii vectoring block
// ----------------------------------------------------------------------------
`ifndef CORDIC_II_VECTORING_ANGLE_MAGNITUDE_MACROS_SVH
`define CORDIC_II_VECTORING_ANGLE_MAGNITUDE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CVAM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CVAM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/cvam_pkg.sv
// ----------------------------------------------------------------------------
// cvam_pkg
// widths, stage constants and shared types of the cordic ii vectoring pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package cvam_pkg;

    localparam int INPUT_WIDTH = 16;
    localparam int FRAC_BITS   = 16;
    localparam int ANG_W       = 26;
    localparam int MAG_W       = 24;
    localparam int MAG_SHIFT   = 8;

    // vector width: input scaled by 256, plus headroom for sqrt(2) growth and gain
    localparam int VW      = INPUT_WIDTH + MAG_SHIFT + 2;
    // numerator width of the divide-by-25 / divide-by-129 rotations
    localparam int FW      = VW + 8;
    localparam int DIV_K   = FW;
    localparam int RECIP_W = DIV_K - 4;
    localparam int QW      = FW - 4;
    localparam int PROD_W  = FW + RECIP_W;
    // numerator width of the power-of-two rotations (shift up to 13, coef up to 8)
    localparam int CHAIN_W = VW + 14;

    localparam int MICRO_RUN = 3;
    localparam int NANO_RUN  = 8;
    localparam int CHAIN_LEN = MICRO_RUN + 2 * NANO_RUN;

    localparam int MAG_MAX = (1 << MAG_W) - 1;
    localparam int SAT_W   = (VW > MAG_W + 1) ? VW : MAG_W + 1;

    localparam int IN_TDATA_W  = ((2 * INPUT_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((ANG_W + MAG_W + 7) / 8) * 8;

    localparam int DIV_FRIEND = 25;
    localparam int DIV_SCALED = 129;
    localparam longint unsigned RECIP_FRIEND = (64'd1 << DIV_K) / DIV_FRIEND;
    localparam longint unsigned RECIP_SCALED = (64'd1 << DIV_K) / DIV_SCALED;

    // stage angles in units of 1e-11 degree
    localparam longint unsigned ANG_UNIT   = 64'd100000000000;
    localparam longint unsigned A_FRIEND1  = 64'd3686989765770;
    localparam longint unsigned A_FRIEND2  = 64'd1626020469640;
    localparam longint unsigned A_SCALED   = 64'd712501637487;
    localparam longint unsigned A_MICRO32  = 64'd178991060651;
    localparam longint unsigned A_MICRO64  = 64'd89517370903;
    localparam longint unsigned A_MICRO128 = 64'd44761417085;
    localparam longint unsigned A_NANO1    = 64'd5595289191;
    localparam longint unsigned A_NANO2    = 64'd699411368;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_90,
        QUAD_180,
        QUAD_270
    } t_quad;

    typedef enum logic [1:0] {
        ROT_FRIEND1,
        ROT_FRIEND2,
        ROT_SCALED
    } t_rot_kind;

    typedef struct packed {
        logic             valid;
        logic             cw;
        logic [ANG_W-1:0] ang;
    } t_side;

    typedef struct packed {
        t_side                  side;
        logic signed [VW-1:0]   x;
        logic signed [VW-1:0]   y;
    } t_vec;

    // degrees in 1e-11 units to 1/2^FRAC_BITS degree, rounded half up
    function automatic logic [ANG_W-1:0] to_fixed(input longint unsigned a);
        longint unsigned q;
        longint unsigned rem;
        longint unsigned f;
        q   = a / ANG_UNIT;
        rem = a % ANG_UNIT;
        f   = ((rem << FRAC_BITS) + ANG_UNIT / 2) / ANG_UNIT;
        return ANG_W'((q << FRAC_BITS) + f);
    endfunction

    localparam logic [ANG_W-1:0] ANG_Q90     = to_fixed(64'd90 * ANG_UNIT);
    localparam logic [ANG_W-1:0] ANG_Q180    = to_fixed(64'd180 * ANG_UNIT);
    localparam logic [ANG_W-1:0] ANG_Q270    = to_fixed(64'd270 * ANG_UNIT);
    localparam logic [ANG_W-1:0] ANG_FRIEND1 = to_fixed(A_FRIEND1);
    localparam logic [ANG_W-1:0] ANG_FRIEND2 = to_fixed(A_FRIEND2);
    localparam logic [ANG_W-1:0] ANG_SCALED  = to_fixed(A_SCALED);

    function automatic int rot_c(input t_rot_kind k);
        case (k)
            ROT_FRIEND1: return 20;
            ROT_FRIEND2: return 24;
            default:     return 128;
        endcase
    endfunction

    function automatic int rot_s(input t_rot_kind k);
        case (k)
            ROT_FRIEND1: return 15;
            ROT_FRIEND2: return 7;
            default:     return 16;
        endcase
    endfunction

    function automatic int rot_r(input t_rot_kind k);
        return (k == ROT_SCALED) ? DIV_SCALED : DIV_FRIEND;
    endfunction

    function automatic logic [ANG_W-1:0] rot_angle(input t_rot_kind k);
        case (k)
            ROT_FRIEND1: return ANG_FRIEND1;
            ROT_FRIEND2: return ANG_FRIEND2;
            default:     return ANG_SCALED;
        endcase
    endfunction

    // micro stages /32 /64 /128, then nano runs /1024 and /8192 with coef 8 down to 1
    function automatic int chain_shift(input int i);
        if (i < MICRO_RUN) return 5 + i;
        if (i < MICRO_RUN + NANO_RUN) return 10;
        return 13;
    endfunction

    function automatic int chain_coef(input int i);
        if (i < MICRO_RUN) return 1;
        if (i < MICRO_RUN + NANO_RUN) return MICRO_RUN + NANO_RUN - i;
        return MICRO_RUN + 2 * NANO_RUN - i;
    endfunction

    function automatic logic [ANG_W-1:0] chain_angle(input int i);
        longint unsigned c;
        c = longint'(chain_coef(i));
        if (i == 0) return to_fixed(A_MICRO32);
        if (i == 1) return to_fixed(A_MICRO64);
        if (i == 2) return to_fixed(A_MICRO128);
        if (i < MICRO_RUN + NANO_RUN) return to_fixed(c * A_NANO1);
        return to_fixed(c * A_NANO2);
    endfunction

endpackage

`default_nettype wire

### sv/cvam_quadrant.sv
// ----------------------------------------------------------------------------
// cvam_quadrant
// scales the input vector and applies the trivial 0/90/180/270 rotation
// ----------------------------------------------------------------------------
`default_nettype none

module cvam_quadrant import cvam_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [INPUT_WIDTH-1:0] i_x_in,
    input  logic signed [INPUT_WIDTH-1:0] i_y_in,
    output t_vec                          o_vec
);

    logic signed [INPUT_WIDTH:0] w_xe, w_ye, w_ax, w_ay;
    logic signed [VW-1:0]        w_xs, w_ys;
    logic                        w_xbig;
    t_quad                       w_quad;

    logic signed [VW-1:0] n_x, n_y;
    logic [ANG_W-1:0]     n_ang;
    logic                 n_cw;

    logic                 r_valid;
    logic signed [VW-1:0] r_x, r_y;
    logic [ANG_W-1:0]     r_ang;
    logic                 r_cw;

    always_comb begin
        w_xe   = (INPUT_WIDTH + 1)'(i_x_in);
        w_ye   = (INPUT_WIDTH + 1)'(i_y_in);
        w_ax   = (w_xe < 0) ? -w_xe : w_xe;
        w_ay   = (w_ye < 0) ? -w_ye : w_ye;
        w_xbig = w_ax > w_ay;
        w_xs   = VW'(i_x_in) <<< MAG_SHIFT;
        w_ys   = VW'(i_y_in) <<< MAG_SHIFT;

        if (w_xe > 0 && w_xbig) begin
            w_quad = QUAD_0;
        end else if (w_xe <= 0 && w_xbig) begin
            w_quad = QUAD_180;
        end else if (w_ye > 0) begin
            w_quad = QUAD_90;
        end else begin
            w_quad = QUAD_270;
        end
    end

    always_comb begin
        unique case (w_quad)
            QUAD_90: begin
                n_x   = w_ys;
                n_y   = -w_xs;
                n_ang = ANG_Q90;
            end
            QUAD_180: begin
                n_x   = -w_xs;
                n_y   = -w_ys;
                n_ang = ANG_Q180;
            end
            QUAD_270: begin
                n_x   = -w_ys;
                n_y   = w_xs;
                n_ang = ANG_Q270;
            end
            default: begin
                n_x   = w_xs;
                n_y   = w_ys;
                n_ang = '0;
            end
        endcase
        // friend-angle direction is fixed here, before the first friend test
        n_cw = n_y > 0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_ang <= n_ang;
            r_cw  <= n_cw;
        end
    end

    assign o_vec.side.valid = r_valid;
    assign o_vec.side.cw    = r_cw;
    assign o_vec.side.ang   = r_ang;
    assign o_vec.x          = r_x;
    assign o_vec.y          = r_y;

endmodule

`default_nettype wire

### sv/cvam_const_div.sv
// ----------------------------------------------------------------------------
// cvam_const_div
// three-stage truncating signed division of two numerators by 25 or 129
// ----------------------------------------------------------------------------
`default_nettype none

module cvam_const_div import cvam_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  t_rot_kind            i_kind,
    input  t_side                i_side,
    input  logic signed [FW-1:0] i_nx,
    input  logic signed [FW-1:0] i_ny,
    output t_side                o_side,
    output logic signed [VW-1:0] o_x,
    output logic signed [VW-1:0] o_y
);

    logic signed [FW-1:0] w_n    [2];
    logic [RECIP_W-1:0]   w_recip;
    logic [FW-1:0]        w_div;
    logic [PROD_W-1:0]    w_prod [2];
    logic [FW-1:0]        w_rem  [2];
    logic [QW-1:0]        w_qc   [2];

    logic                 n_m_neg [2];
    logic [FW-1:0]        n_m_abs [2];
    logic [QW-1:0]        n_m_q   [2];
    logic                 n_c_inc [2];
    logic signed [VW-1:0] n_d_x   [2];

    // multiply stage
    logic                 r_m_valid;
    t_side                r_m_side;
    logic                 r_m_neg [2];
    logic [FW-1:0]        r_m_abs [2];
    logic [QW-1:0]        r_m_q   [2];
    // correction stage
    logic                 r_c_valid;
    t_side                r_c_side;
    logic                 r_c_neg [2];
    logic [QW-1:0]        r_c_q   [2];
    logic                 r_c_inc [2];
    // sign stage
    logic                 r_d_valid;
    t_side                r_d_side;
    logic signed [VW-1:0] r_d_x   [2];

    assign w_n[0]  = i_nx;
    assign w_n[1]  = i_ny;
    assign w_recip = (i_kind == ROT_SCALED) ? RECIP_W'(RECIP_SCALED) : RECIP_W'(RECIP_FRIEND);
    assign w_div   = FW'(rot_r(i_kind));

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_m_neg[l] = w_n[l][FW-1];
            n_m_abs[l] = n_m_neg[l] ? FW'(-w_n[l]) : FW'(w_n[l]);
            // reciprocal estimate is the true quotient or one below it
            w_prod[l]  = PROD_W'(n_m_abs[l]) * PROD_W'(w_recip);
            n_m_q[l]   = QW'(w_prod[l] >> DIV_K);
            w_rem[l]   = r_m_abs[l] - FW'(r_m_q[l]) * w_div;
            n_c_inc[l] = w_rem[l] >= w_div;
            w_qc[l]    = r_c_q[l] + QW'(r_c_inc[l]);
            n_d_x[l]   = r_c_neg[l] ? -VW'(w_qc[l]) : VW'(w_qc[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (i_en) begin
            r_m_valid <= i_side.valid;
            r_c_valid <= r_m_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_side <= i_side;
            r_c_side <= r_m_side;
            r_d_side <= r_c_side;
            for (int l = 0; l < 2; l++) begin
                r_m_neg[l] <= n_m_neg[l];
                r_m_abs[l] <= n_m_abs[l];
                r_m_q[l]   <= n_m_q[l];
                r_c_neg[l] <= r_m_neg[l];
                r_c_q[l]   <= r_m_q[l];
                r_c_inc[l] <= n_c_inc[l];
                r_d_x[l]   <= n_d_x[l];
            end
        end
    end

    assign o_side.valid = r_d_valid;
    assign o_side.cw    = r_d_side.cw;
    assign o_side.ang   = r_d_side.ang;
    assign o_x          = r_d_x[0];
    assign o_y          = r_d_x[1];

endmodule

`default_nettype wire

### sv/cvam_rot_stage.sv
// ----------------------------------------------------------------------------
// cvam_rot_stage
// friend-angle or scaled rotation: numerator stage followed by the divider
// ----------------------------------------------------------------------------
`default_nettype none

module cvam_rot_stage import cvam_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_rot_kind i_kind,
    input  t_vec      i_vec,
    output t_vec      o_vec
);

    logic signed [VW-1:0] w_x, w_y;
    logic signed [FW-1:0] w_c, w_s, w_r;
    logic signed [FW-1:0] w_xe, w_ye, w_dy;
    logic signed [FW-1:0] w_cx, w_cy, w_sx, w_sy;
    logic signed [FW-1:0] w_rx, w_ry;
    logic                 w_cw, w_take;
    logic [ANG_W-1:0]     w_step;

    logic signed [FW-1:0] n_nx, n_ny;
    logic [ANG_W-1:0]     n_ang;

    logic                 r_valid;
    logic                 r_cw;
    logic [ANG_W-1:0]     r_ang;
    logic signed [FW-1:0] r_nx, r_ny;

    t_side                w_side;

    assign w_x    = i_vec.x;
    assign w_y    = i_vec.y;
    assign w_c    = FW'(rot_c(i_kind));
    assign w_s    = FW'(rot_s(i_kind));
    assign w_r    = FW'(rot_r(i_kind));
    assign w_step = rot_angle(i_kind);

    always_comb begin
        // friend stages keep the direction chosen before the first test
        w_cw = (i_kind == ROT_SCALED) ? (w_y > 0) : i_vec.side.cw;
        w_xe = FW'(w_x);
        w_ye = FW'(w_y);
        w_cx = w_c * w_xe;
        w_cy = w_c * w_ye;
        w_sx = w_s * w_xe;
        w_sy = w_s * w_ye;
        w_dy = w_cw ? w_ye : -w_ye;
        w_take = (i_kind == ROT_SCALED) || (w_c * w_dy > w_sx);

        if (w_cw) begin
            w_rx = w_cx + w_sy;
            w_ry = w_cy - w_sx;
        end else begin
            w_rx = w_cx - w_sy;
            w_ry = w_cy + w_sx;
        end

        if (w_take) begin
            n_nx  = w_rx;
            n_ny  = w_ry;
            n_ang = w_cw ? (i_vec.side.ang + w_step) : (i_vec.side.ang - w_step);
        end else begin
            // skipped rotation: exact multiple of the divisor passes x and y through
            n_nx  = w_r * w_xe;
            n_ny  = w_r * w_ye;
            n_ang = i_vec.side.ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_vec.side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cw  <= i_vec.side.cw;
            r_ang <= n_ang;
            r_nx  <= n_nx;
            r_ny  <= n_ny;
        end
    end

    assign w_side.valid = r_valid;
    assign w_side.cw    = r_cw;
    assign w_side.ang   = r_ang;

    cvam_const_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_kind  (i_kind),
        .i_side  (w_side),
        .i_nx    (r_nx),
        .i_ny    (r_ny),
        .o_side  (o_vec.side),
        .o_x     (o_vec.x),
        .o_y     (o_vec.y)
    );

endmodule

`default_nettype wire

### sv/cvam_shift_chain.sv
// ----------------------------------------------------------------------------
// cvam_shift_chain
// micro and nano rotations with power-of-two divisors, one rotation per stage
// ----------------------------------------------------------------------------
`default_nettype none

module cvam_shift_chain import cvam_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_vec i_vec,
    output t_vec o_vec
);

    logic                 r_valid [CHAIN_LEN];
    logic signed [VW-1:0] r_x     [CHAIN_LEN];
    logic signed [VW-1:0] r_y     [CHAIN_LEN];
    logic [ANG_W-1:0]     r_ang   [CHAIN_LEN];

    for (genvar g = 0; g < CHAIN_LEN; g++) begin : g_stage
        localparam int SH = chain_shift(g);
        localparam logic signed [CHAIN_W-1:0] COEF      = CHAIN_W'(chain_coef(g));
        localparam logic signed [CHAIN_W-1:0] BIAS      = CHAIN_W'((1 << SH) - 1);
        localparam logic signed [CHAIN_W-1:0] BIAS_NONE = '0;
        localparam logic [ANG_W-1:0]          STEP      = chain_angle(g);

        logic                      w_v;
        logic signed [VW-1:0]      w_x, w_y;
        logic [ANG_W-1:0]          w_a;
        logic                      w_cw;
        logic signed [CHAIN_W-1:0] w_xe, w_ye, w_nx, w_ny, w_tx, w_ty;
        logic signed [VW-1:0]      n_x, n_y;
        logic [ANG_W-1:0]          n_a;

        if (g == 0) begin : g_head
            assign w_v = i_vec.side.valid;
            assign w_x = i_vec.x;
            assign w_y = i_vec.y;
            assign w_a = i_vec.side.ang;
        end else begin : g_body
            assign w_v = r_valid[g-1];
            assign w_x = r_x[g-1];
            assign w_y = r_y[g-1];
            assign w_a = r_ang[g-1];
        end

        always_comb begin
            w_cw = w_y > 0;
            w_xe = CHAIN_W'(w_x);
            w_ye = CHAIN_W'(w_y);
            if (w_cw) begin
                w_nx = (w_xe <<< SH) + COEF * w_ye;
                w_ny = (w_ye <<< SH) - COEF * w_xe;
                n_a  = w_a + STEP;
            end else begin
                w_nx = (w_xe <<< SH) - COEF * w_ye;
                w_ny = (w_ye <<< SH) + COEF * w_xe;
                n_a  = w_a - STEP;
            end
            // truncate toward zero: bias negative numerators before the shift
            w_tx = w_nx + (w_nx[CHAIN_W-1] ? BIAS : BIAS_NONE);
            w_ty = w_ny + (w_ny[CHAIN_W-1] ? BIAS : BIAS_NONE);
            n_x  = VW'(w_tx >>> SH);
            n_y  = VW'(w_ty >>> SH);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g]   <= n_x;
                r_y[g]   <= n_y;
                r_ang[g] <= n_a;
            end
        end
    end

    assign o_vec.side.valid = r_valid[CHAIN_LEN-1];
    assign o_vec.side.cw    = r_y[CHAIN_LEN-1] > 0;
    assign o_vec.side.ang   = r_ang[CHAIN_LEN-1];
    assign o_vec.x          = r_x[CHAIN_LEN-1];
    assign o_vec.y          = r_y[CHAIN_LEN-1];

endmodule

`default_nettype wire

### sv/cordic_ii_vectoring_angle_magnitude.sv
// ----------------------------------------------------------------------------
// cordic_ii_vectoring_angle_magnitude
// Angle and uncompensated magnitude of a signed x,y vector by CORDIC II
// vectoring. Unless held, the pipeline takes one vector every clock and registers
// it through the quadrant rotation; the numerator, reciprocal multiply,
// remainder check and sign registers of each of the two friend-angle
// rotations and the scaled rotation; one register per micro and nano
// rotation (19); and the output register with magnitude clamping.
// All stages advance together; when a result sits in the output register and
// is not taken, the whole pipeline holds and no new vector is accepted. The
// angle is in 1/65536 degree, wrapping at 26 bits; the magnitude is in 1/256
// units, clamped to 0 and 2^24-1.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cordic_ii_vectoring_angle_magnitude_macros.svh"

module cordic_ii_vectoring_angle_magnitude import cvam_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // x_in, y_in, zero fill
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata   // angle_out, magnitude_out, zero fill
);

    logic                  w_en;
    t_vec                  w_quad, w_fr1, w_fr2, w_scl, w_chain;
    logic signed [SAT_W-1:0] w_xs;
    logic [MAG_W-1:0]      n_mag;

    logic                  r_out_valid;
    logic [ANG_W-1:0]      r_out_ang;
    logic [MAG_W-1:0]      r_out_mag;

    localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(MAG_MAX);

    // whole pipeline advances unless the output register holds an untaken result
    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    cvam_quadrant u_quad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_x_in  (i_s_axis_tdata[INPUT_WIDTH-1:0]),
        .i_y_in  (i_s_axis_tdata[2*INPUT_WIDTH-1:INPUT_WIDTH]),
        .o_vec   (w_quad)
    );

    cvam_rot_stage u_friend1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_kind  (ROT_FRIEND1),
        .i_vec   (w_quad),
        .o_vec   (w_fr1)
    );

    cvam_rot_stage u_friend2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_kind  (ROT_FRIEND2),
        .i_vec   (w_fr1),
        .o_vec   (w_fr2)
    );

    cvam_rot_stage u_scaled (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_kind  (ROT_SCALED),
        .i_vec   (w_fr2),
        .o_vec   (w_scl)
    );

    cvam_shift_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vec   (w_scl),
        .o_vec   (w_chain)
    );

    always_comb begin
        w_xs = SAT_W'(w_chain.x);
        if (w_xs < 0) begin
            n_mag = '0;
        end else if (w_xs > SAT_MAX) begin
            n_mag = MAG_W'(MAG_MAX);
        end else begin
            n_mag = w_xs[MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_chain.side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_ang <= w_chain.side.ang;
            r_out_mag <= n_mag;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out_mag, r_out_ang});

    `CVAM_ASSERT_IMPL(a_stall_blocks_input, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, !o_s_axis_tready, "vector accepted while output stalled")

    `CVAM_ASSERT_NEXT(a_chain_to_output, i_clk, i_rst_n, w_chain.side.valid && w_en, o_m_axis_tvalid, "finished vector did not reach output")

    `CVAM_ASSERT_NEXT(a_drain_empties, i_clk, i_rst_n, o_m_axis_tvalid && i_m_axis_tready && !w_chain.side.valid, !o_m_axis_tvalid, "result repeated after transaction")

endmodule

`default_nettype wire

### bench/vector_polar_checker.sv
// ----------------------------------------------------------------------------
// vector_polar_checker
// Watches both stream channels of the cordic ii vectoring block, predicts the
// angle and magnitude of every accepted vector, and compares each result
// transaction against the oldest pending prediction.
// ----------------------------------------------------------------------------
module vector_polar_checker import cvam_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    input  logic                   i_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // x_in, y_in
    input  logic                   i_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_axis_tdata,   // angle_out, magnitude_out, zero fill
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned E11_PER_DEG = 64'd100000000000;

    // stage angles in 1e-11 degree
    localparam longint unsigned FRIEND1_E11 = 64'd3686989765770;
    localparam longint unsigned FRIEND2_E11 = 64'd1626020469640;
    localparam longint unsigned SCALED_E11  = 64'd712501637487;
    localparam longint unsigned MICRO32_E11 = 64'd178991060651;
    localparam longint unsigned MICRO64_E11 = 64'd89517370903;
    localparam longint unsigned MICRO128_E11 = 64'd44761417085;
    localparam longint unsigned NANO1K_E11  = 64'd5595289191;
    localparam longint unsigned NANO8K_E11  = 64'd699411368;

    typedef struct {
        logic signed [INPUT_WIDTH-1:0] x;
        logic signed [INPUT_WIDTH-1:0] y;
        logic [ANG_W-1:0]              angle;
        logic [MAG_W-1:0]              mag;
    } t_polar;

    typedef struct {
        longint x;
        longint y;
        longint ang;
    } t_rot_state;

    t_polar polar_expected[$];
    int     fail_count = 0;
    int     checked    = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = polar_expected.size();
    assign o_checked    = checked;

    // degrees in 1e-11 units to 1/65536 degree, halves rounded up
    function automatic longint unsigned deg_to_units(input longint unsigned e11);
        return (e11 * 64'd65536 + E11_PER_DEG / 2) / E11_PER_DEG;
    endfunction

    function automatic t_rot_state turn(input t_rot_state v, input int c, input int s,
                                        input int r, input bit cw,
                                        input longint unsigned e11);
        t_rot_state n;
        longint     nx;
        longint     ny;
        if (cw) begin
            nx    = c * v.x + s * v.y;
            ny    = c * v.y - s * v.x;
            n.ang = v.ang + longint'(deg_to_units(e11));
        end else begin
            nx    = c * v.x - s * v.y;
            ny    = c * v.y + s * v.x;
            n.ang = v.ang - longint'(deg_to_units(e11));
        end
        // signed division truncates toward zero
        n.x = nx / r;
        n.y = ny / r;
        return n;
    endfunction

    function automatic t_polar predict_polar(input logic signed [INPUT_WIDTH-1:0] vx,
                                             input logic signed [INPUT_WIDTH-1:0] vy);
        t_polar     p;
        t_rot_state v;
        longint     ax;
        longint     ay;
        longint     t;
        t_quad      quad;
        bit         cw;
        v.x   = longint'(vx) * 256;
        v.y   = longint'(vy) * 256;
        v.ang = 0;
        ax    = (v.x < 0) ? -v.x : v.x;
        ay    = (v.y < 0) ? -v.y : v.y;
        quad  = QUAD_0;
        if (v.x > 0) begin
            if (ax <= ay) quad = (v.y > 0) ? QUAD_90 : QUAD_270;
        end else if (ax > ay) begin
            quad = QUAD_180;
        end else begin
            quad = (v.y > 0) ? QUAD_90 : QUAD_270;
        end
        case (quad)
            QUAD_90: begin
                t = v.x; v.x = v.y; v.y = -t;
            end
            QUAD_180: begin
                v.x = -v.x; v.y = -v.y;
            end
            QUAD_270: begin
                t = v.x; v.x = -v.y; v.y = t;
            end
            default: ;
        endcase
        v.ang = longint'(deg_to_units(longint'(quad) * 90 * E11_PER_DEG));

        // friend tests share the direction taken before the first one
        cw = v.y > 0;
        if (20 * (cw ? v.y : -v.y) > 15 * v.x) v = turn(v, 20, 15, 25, cw, FRIEND1_E11);
        if (24 * (cw ? v.y : -v.y) > 7 * v.x) v = turn(v, 24, 7, 25, cw, FRIEND2_E11);

        v = turn(v, 128, 16, 129, v.y > 0, SCALED_E11);
        v = turn(v, 32, 1, 32, v.y > 0, MICRO32_E11);
        v = turn(v, 64, 1, 64, v.y > 0, MICRO64_E11);
        v = turn(v, 128, 1, 128, v.y > 0, MICRO128_E11);
        for (int i = 8; i > 0; i--) begin
            v = turn(v, 1024, i, 1024, v.y > 0, longint'(i) * NANO1K_E11);
        end
        for (int i = 8; i > 0; i--) begin
            v = turn(v, 8192, i, 8192, v.y > 0, longint'(i) * NANO8K_E11);
        end

        if (v.x < 0) v.x = 0;
        if (v.x > MAG_MAX) v.x = MAG_MAX;
        p.x     = vx;
        p.y     = vy;
        p.angle = ANG_W'(v.ang);
        p.mag   = MAG_W'(v.x);
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_polar           want;
        logic [ANG_W-1:0] got_angle;
        logic [MAG_W-1:0] got_mag;
        if (i_rst_n) begin
            // results first, a vector taken in this cycle cannot be among them
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got_angle = i_m_axis_tdata[ANG_W-1:0];
                got_mag   = i_m_axis_tdata[ANG_W +: MAG_W];
                if (polar_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected result angle=%0h mag=%0h",
                                              got_angle, got_mag));
                end else begin
                    want = polar_expected.pop_front();
                    checked++;
                    if (got_angle !== want.angle)
                        report_mismatch($sformatf("x=%0d y=%0d angle got %0h want %0h",
                                                  want.x, want.y, got_angle, want.angle));
                    if (got_mag !== want.mag)
                        report_mismatch($sformatf("x=%0d y=%0d magnitude got %0h want %0h",
                                                  want.x, want.y, got_mag, want.mag));
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                polar_expected.push_back(predict_polar(
                    i_s_axis_tdata[INPUT_WIDTH-1:0],
                    i_s_axis_tdata[INPUT_WIDTH +: INPUT_WIDTH]));
            end
        end
    end

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the cordic ii vectoring block: directed vectors on
// the axes, diagonals and extremes, then random vectors with random idling on
// both sides, a long receiver hold-off and drain pauses. The checker module
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb import cvam_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 300;

    logic                   i_clk     = 1'b0;
    logic                   i_rst_n   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int checked;
    int sent = 0;

    // random idling on both sides when set
    bit throttle = 1'b0;
    // receiver hold-off request, cleared by the receiver when done
    bit hold_rx = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    cordic_ii_vectoring_angle_magnitude dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    vector_polar_checker chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    task automatic offer_vector(input logic signed [INPUT_WIDTH-1:0] vx,
                                input logic signed [INPUT_WIDTH-1:0] vy);
        while (throttle && $urandom_range(0, 99) < 34) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {vy, vx};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
    endtask

    task automatic pick_vector(output logic signed [INPUT_WIDTH-1:0] vx,
                               output logic signed [INPUT_WIDTH-1:0] vy);
        logic signed [INPUT_WIDTH-1:0] corner[7];
        int                            sel;
        corner = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32766, 16'sd32767};
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            vx = INPUT_WIDTH'($urandom);
            vy = INPUT_WIDTH'($urandom);
        end else if (sel < 75) begin
            vx = INPUT_WIDTH'($signed($urandom_range(0, 16)) - 8);
            vy = INPUT_WIDTH'($signed($urandom_range(0, 16)) - 8);
        end else if (sel < 85) begin
            // close to an axis
            vx = INPUT_WIDTH'($urandom);
            vy = INPUT_WIDTH'($signed($urandom_range(0, 6)) - 3);
            if ($urandom_range(0, 1)) begin
                vy = vx;
                vx = INPUT_WIDTH'($signed($urandom_range(0, 6)) - 3);
            end
        end else if (sel < 93) begin
            // equal magnitudes, random signs
            vx = INPUT_WIDTH'($urandom_range(0, 32767));
            vy = $urandom_range(0, 1) ? -vx : vx;
            if ($urandom_range(0, 1)) vx = -vx;
        end else begin
            vx = corner[$urandom_range(0, 6)];
            vy = corner[$urandom_range(0, 6)];
        end
    endtask

    task automatic random_run(input int count);
        logic signed [INPUT_WIDTH-1:0] vx;
        logic signed [INPUT_WIDTH-1:0] vy;
        repeat (count) begin
            pick_vector(vx, vy);
            offer_vector(vx, vy);
        end
    endtask

    // receiver
    initial begin
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_rx = 1'b0;
            end else if (throttle && $urandom_range(0, 99) < 34) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("** cordic_ii_vectoring_angle_magnitude: FAILED **");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        throttle = 1'b1;
        // zero vector, axes, diagonals, extremes, |x| against |y| ties
        offer_vector(16'sd0, 16'sd0);
        offer_vector(16'sd32767, 16'sd0);
        offer_vector(-16'sd32768, 16'sd0);
        offer_vector(16'sd0, 16'sd32767);
        offer_vector(16'sd0, -16'sd32768);
        offer_vector(16'sd32767, 16'sd32767);
        offer_vector(-16'sd32768, -16'sd32768);
        offer_vector(16'sd32767, -16'sd32768);
        offer_vector(-16'sd32768, 16'sd32767);
        offer_vector(16'sd1, 16'sd1);
        offer_vector(-16'sd1, -16'sd1);
        offer_vector(16'sd1, -16'sd1);
        offer_vector(-16'sd1, 16'sd1);
        offer_vector(16'sd100, 16'sd100);
        offer_vector(-16'sd100, 16'sd100);
        offer_vector(-16'sd100, -16'sd100);
        offer_vector(16'sd100, -16'sd100);
        offer_vector(16'sd5, 16'sd3);
        offer_vector(-16'sd5, 16'sd3);
        offer_vector(16'sd3, -16'sd5);
        offer_vector(16'sd0, 16'sd1);
        offer_vector(16'sd0, -16'sd1);
        offer_vector(16'sd1, 16'sd0);
        offer_vector(-16'sd1, 16'sd0);
        offer_vector(16'sd20000, 16'sd15001);
        drain_results();

        random_run(600);

        // no idling; receiver holds off long enough for the pipeline to fill
        throttle = 1'b0;
        hold_rx  = 1'b1;
        random_run(400);
        drain_results();

        throttle = 1'b1;
        random_run(700);

        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (40) @(posedge i_clk);

        $display("covered %0d vectors: zero, axes, diagonals, extremes and random, with stalls",
                 sent);
        $display("%0d results compared against the predicted angle and magnitude", checked);
        if (fail_count == 0) begin
            $display("** cordic_ii_vectoring_angle_magnitude: PASSED **");
        end else begin
            $display("** cordic_ii_vectoring_angle_magnitude: FAILED **");
        end
        $finish;
    end

endmodule
